// ----- rtl/fccb_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunk class builder package
// Shared sizes, operation codes and the class table request type.
// ----------------------------------------------------------------------------
package fccb_pkg;

  localparam int MAX_RULES   = 64;
  localparam int MAX_CLASSES = 256;
  localparam int POINT_COUNT = 65536;

  localparam int RULE_AW  = 6;   // address of one rule range
  localparam int RULE_CW  = 7;   // rule count, holds MAX_RULES itself
  localparam int CLASS_AW = 8;   // address of one class bitmap
  localparam int CNT_W    = 9;   // class count, holds MAX_CLASSES itself
  localparam int POINT_W  = 17;  // point counter, holds POINT_COUNT itself
  localparam int VAL_W    = 16;  // one dimension value
  localparam int BITMAP_W = 64;  // one match bit per rule

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  typedef logic [BITMAP_W-1:0] bitmap_t;

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [CLASS_AW-1:0] addr;
  } class_req_t;

endpackage

// ----- rtl/fccb_class_table.sv -----
// ----------------------------------------------------------------------------
// Equivalence class table
// Stores one match bitmap per class and compares the entry read in the
// previous cycle against the current key.
// ----------------------------------------------------------------------------
module fccb_class_table (
  input  logic               clk,
  input  fccb_pkg::class_req_t req,
  input  fccb_pkg::bitmap_t  key,    // write data and compare key
  output logic               match
);

  fccb_pkg::bitmap_t mem [fccb_pkg::MAX_CLASSES];
  fccb_pkg::bitmap_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= key;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  // The key does not change while a search runs.
  assign match = (rdata_r == key);

endmodule

// ----- rtl/flow_chunk_class_builder_top.sv -----
// ----------------------------------------------------------------------------
// Flow chunk class builder
// Builds one phase-0 chunk of a recursive flow classifier for a 16-bit field.
// ----------------------------------------------------------------------------
// One item is taken at a time. Clear and load items are handled as they are
// accepted. A step item walks the active rules one per cycle through the rule
// range memory to update the match bitmap, then walks the class table one
// entry per cycle through its single read port, comparing each stored bitmap
// with one 64-bit comparator, and appends the bitmap when no entry matches and
// the table has room; with a full table it reports table_full instead. A
// finished result sits in an output register, so the next item is accepted
// while it waits; the block only stalls when a second result is ready before
// the first one was taken. Rule ranges and class bitmaps are not cleared by
// reset; a step must only cover rules that were loaded.
module flow_chunk_class_builder_top (
  input  logic        clk,
  input  logic        rst_n,

  // Configuration write: rule_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // rule_index[5:0], range_start[21:6],
                                  // range_end[37:22], zero fill
  input  logic [1:0]  in_tuser,   // opcode[1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // point_value[15:0], class_id[23:16],
                                  // classes_so_far[32:24], zero fill
  output logic [1:0]  out_tuser,  // new_class[0], table_full[1]
  output logic        out_tlast   // last_point
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RULE  = 2'd1;
  localparam logic [1:0] ST_CLASS = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                   state_r;
  logic [fccb_pkg::RULE_CW-1:0] rule_count_r;
  logic [fccb_pkg::POINT_W-1:0] next_point_r;
  logic [fccb_pkg::CNT_W-1:0]   class_total_r;
  fccb_pkg::bitmap_t            bitmap_r;

  // Rule range memories, registered read.
  logic [fccb_pkg::VAL_W-1:0]   lows_mem  [fccb_pkg::MAX_RULES];
  logic [fccb_pkg::VAL_W-1:0]   highs_mem [fccb_pkg::MAX_RULES];
  logic [fccb_pkg::VAL_W-1:0]   rlow_r;
  logic [fccb_pkg::VAL_W-1:0]   rhigh_r;

  logic [fccb_pkg::RULE_CW-1:0] ri_r;     // next rule to read
  logic                         rvld_r;   // rule data valid
  logic [fccb_pkg::RULE_AW-1:0] ridx_r;   // rule the data belongs to

  logic [fccb_pkg::CNT_W-1:0]    ci_r;    // next class to read
  logic                          cvld_r;  // class data valid
  logic [fccb_pkg::CLASS_AW-1:0] cidx_r;  // class the data belongs to

  logic [fccb_pkg::CLASS_AW-1:0] p_id_r;
  logic                          p_new_r;
  logic                          p_full_r;

  logic                          out_valid_r;
  logic [fccb_pkg::VAL_W-1:0]    out_point_r;
  logic [fccb_pkg::CLASS_AW-1:0] out_id_r;
  logic                          out_new_r;
  logic                          out_full_r;
  logic [fccb_pkg::CNT_W-1:0]    out_total_r;
  logic                          out_last_r;

  logic [fccb_pkg::RULE_CW-1:0] active;
  logic                         in_acc;
  logic                         rule_rd;
  logic                         rule_hit_set;
  logic                         rule_hit_clr;
  logic                         class_match;
  logic                         class_rd;
  logic                         class_miss;
  logic                         class_room;
  logic                         out_free;
  logic                         out_load;
  fccb_pkg::class_req_t         creq;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Counts above the rule memory depth act as the full depth.
  assign active = (rule_count_r > fccb_pkg::RULE_CW'(fccb_pkg::MAX_RULES)) ?
                  fccb_pkg::RULE_CW'(fccb_pkg::MAX_RULES) : rule_count_r;

  assign rule_rd = (state_r == ST_RULE) && (ri_r < active);

  // A range starts at its low value and stops one past its high value; the
  // 17-bit sum keeps a range that ends at the top value from ever stopping.
  assign rule_hit_set = ({1'b0, rlow_r} == next_point_r);
  assign rule_hit_clr = (({1'b0, rhigh_r} + fccb_pkg::POINT_W'(1)) == next_point_r);

  assign class_room = (class_total_r < fccb_pkg::CNT_W'(fccb_pkg::MAX_CLASSES));
  assign class_rd   = (state_r == ST_CLASS) && !(cvld_r && class_match) &&
                      (ci_r < class_total_r);
  assign class_miss = (state_r == ST_CLASS) && !cvld_r && !(ci_r < class_total_r);

  always_comb begin
    creq.rd_en = class_rd;
    creq.wr_en = class_miss && class_room;
    creq.addr  = class_rd ? ci_r[fccb_pkg::CLASS_AW-1:0]
                          : class_total_r[fccb_pkg::CLASS_AW-1:0];
  end

  fccb_class_table u_class_table (
    .clk   (clk),
    .req   (creq),
    .key   (bitmap_r),
    .match (class_match)
  );

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == fccb_pkg::OP_LOAD)) begin
      lows_mem[in_tdata[5:0]]  <= in_tdata[21:6];
      highs_mem[in_tdata[5:0]] <= in_tdata[37:22];
    end
    if (rule_rd) begin
      rlow_r  <= lows_mem[ri_r[fccb_pkg::RULE_AW-1:0]];
      rhigh_r <= highs_mem[ri_r[fccb_pkg::RULE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rule_count_r  <= '0;
      next_point_r  <= '0;
      class_total_r <= '0;
      bitmap_r      <= '0;
      ri_r          <= '0;
      rvld_r        <= 1'b0;
      ridx_r        <= '0;
      ci_r          <= '0;
      cvld_r        <= 1'b0;
      cidx_r        <= '0;
      p_id_r        <= '0;
      p_new_r       <= 1'b0;
      p_full_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rule_count_r <= cfg_data;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            priority if (in_tuser == fccb_pkg::OP_CLEAR) begin
              class_total_r <= '0;
              bitmap_r      <= '0;
              next_point_r  <= '0;
            end else if ((in_tuser == fccb_pkg::OP_STEP) &&
                         (next_point_r < fccb_pkg::POINT_W'(fccb_pkg::POINT_COUNT))) begin
              ri_r    <= '0;
              rvld_r  <= 1'b0;
              state_r <= ST_RULE;
            end else begin
              // Loads write the rule memories above; other codes do nothing.
            end
          end
        end

        ST_RULE: begin
          if (rvld_r) begin
            if (rule_hit_clr) begin
              bitmap_r[ridx_r] <= 1'b0;
            end else if (rule_hit_set) begin
              bitmap_r[ridx_r] <= 1'b1;
            end
          end
          if (rule_rd) begin
            rvld_r <= 1'b1;
            ridx_r <= ri_r[fccb_pkg::RULE_AW-1:0];
            ri_r   <= ri_r + fccb_pkg::RULE_CW'(1);
          end else begin
            rvld_r <= 1'b0;
            if (!rvld_r) begin
              ci_r    <= '0;
              cvld_r  <= 1'b0;
              state_r <= ST_CLASS;
            end
          end
        end

        ST_CLASS: begin
          priority if (cvld_r && class_match) begin
            p_id_r   <= cidx_r;
            p_new_r  <= 1'b0;
            p_full_r <= 1'b0;
            state_r  <= ST_FIN;
          end else if (class_rd) begin
            cvld_r <= 1'b1;
            cidx_r <= ci_r[fccb_pkg::CLASS_AW-1:0];
            ci_r   <= ci_r + fccb_pkg::CNT_W'(1);
          end else if (class_miss) begin
            if (class_room) begin
              p_id_r        <= class_total_r[fccb_pkg::CLASS_AW-1:0];
              p_new_r       <= 1'b1;
              p_full_r      <= 1'b0;
              class_total_r <= class_total_r + fccb_pkg::CNT_W'(1);
            end else begin
              p_id_r   <= fccb_pkg::CLASS_AW'(fccb_pkg::MAX_CLASSES - 1);
              p_new_r  <= 1'b0;
              p_full_r <= 1'b1;
            end
            state_r <= ST_FIN;
          end else begin
            // The last entry read did not match; let the pipe drain.
            cvld_r <= 1'b0;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            next_point_r <= next_point_r + fccb_pkg::POINT_W'(1);
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded together with the valid flag.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_point_r <= next_point_r[fccb_pkg::VAL_W-1:0];
      out_id_r    <= p_id_r;
      out_new_r   <= p_new_r;
      out_full_r  <= p_full_r;
      out_total_r <= class_total_r;
      out_last_r  <= (next_point_r == fccb_pkg::POINT_W'(fccb_pkg::POINT_COUNT - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_total_r, out_id_r, out_point_r};
  assign out_tuser  = {out_full_r, out_new_r};
  assign out_tlast  = out_last_r;

endmodule
